// File: hw/rtl/btmu_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and types of the birdie table unit.
package btmu_pkg;

  localparam int TABLE_DEPTH    = 256;
  localparam int IDX_W          = $clog2(TABLE_DEPTH);
  localparam int USED_W         = IDX_W + 1;
  localparam int INTERVAL_COUNT = 1024;
  localparam int CHANNEL_COUNT  = 1024;
  localparam int BMAP_WORDS     = (INTERVAL_COUNT + 63) / 64;
  localparam int WSEL_W         = $clog2(BMAP_WORDS);
  localparam int BMAP_DEPTH     = TABLE_DEPTH * BMAP_WORDS;
  localparam int BMAP_AW        = IDX_W + WSEL_W;

  localparam int FREQ_W   = 48;
  localparam int SIG_W    = 32;
  localparam int SPREAD_W = 64;
  localparam int CNT_W    = 24;
  localparam int TOL_W    = 24;
  localparam int WORD_W   = 64;
  localparam int POS_W    = 10;
  localparam int MUL_W    = 24;
  localparam int ACC_W    = 96;
  localparam int DIVR_W   = 26;
  localparam int DIV_STEPS = ACC_W;
  localparam int DIVC_W   = $clog2(DIV_STEPS);
  localparam logic [DIVC_W-1:0] DIV_LAST = DIVC_W'(DIV_STEPS - 1);

  localparam logic [CNT_W-1:0] CNT_MAX   = '1;
  localparam logic [TOL_W-1:0] TOL_RESET = 24'd1677722;

  localparam int CFG_AW = 3;
  localparam logic REG_TOL_IDX = 1'b0;

  typedef enum logic [1:0] {
    CMD_FIND   = 2'd0,
    CMD_UPDATE = 2'd1,
    CMD_READ   = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_NOMATCH = 2'd1,
    STAT_BADIDX  = 2'd2
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_FIND_MUL,
    S_FIND_SCAN,
    S_UPD_RD,
    S_UPD_LAT,
    S_UPD_SWEEP,
    S_UPD_BITS,
    S_UPD_MM,
    S_UPD_DIV_T2,
    S_UPD_SP,
    S_UPD_DIV_T1,
    S_UPD_DIV_M,
    S_UPD_DIV_S,
    S_UPD_WR,
    S_RD_ISSUE,
    S_RD_DATA,
    S_DONE
  } state_t;

endpackage

// File: hw/rtl/birdie_table_match_update_unit.sv
`timescale 1ns / 1ps
// Birdie table: tone match search, Welford running statistics and entry read.
// One request at a time; in_stall is high while a request is in work. A find
// scans the used entries in order up to the first match (the mean memory is
// read once a cycle); an append sweeps the bitmap rows of the new entry one
// word a cycle; an update of an existing entry uses one shared 24x24
// multiplier and one bit-serial divider that performs four 96-step divisions.
// The finished result sits in an output register, so the next request is
// taken while it waits. Table memory needs no clearing after reset: an entry
// is initialized when it is appended.
module birdie_table_match_update_unit
  import btmu_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_command,
  input  logic [IDX_W-1:0]    in_entry_index,
  input  logic [FREQ_W-1:0]   in_tone_freq,
  input  logic [SIG_W-1:0]    in_tone_sigma,
  input  logic [POS_W-1:0]    in_chan_number,
  input  logic [POS_W-1:0]    in_interval_number,
  input  logic [WSEL_W-1:0]   in_word_select,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_status,
  output logic [IDX_W-1:0]    out_match_index,
  output logic [FREQ_W-1:0]   out_freq_mean,
  output logic [SPREAD_W-1:0] out_freq_spread,
  output logic [SIG_W-1:0]    out_sigma_mean,
  output logic [CNT_W-1:0]    out_obs_count,
  output logic [WORD_W-1:0]   out_time_word,
  output logic [WORD_W-1:0]   out_chan_word,
  output logic [USED_W-1:0]   out_entries_in_use,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CFG_AW-1:0]   paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  state_t state_r, state_nxt;

  logic [TOL_W-1:0]  tol_r;
  logic [USED_W-1:0] used_r, used_nxt;

  logic [IDX_W-1:0]  e_r, e_nxt;
  logic [FREQ_W-1:0] f_r, f_nxt;
  logic [SIG_W-1:0]  s_r, s_nxt;
  logic [POS_W-1:0]  iv_r, iv_nxt, ch_r, ch_nxt;
  logic [WSEL_W-1:0] ws_r, ws_nxt;
  logic              append_r, append_nxt;

  logic [FREQ_W-1:0]   mean_q_r, mean_q_nxt;
  logic [SPREAD_W-1:0] spread_q_r, spread_q_nxt;
  logic [SIG_W-1:0]    sig_q_r, sig_q_nxt;
  logic [CNT_W-1:0]    cnt_q_r, cnt_q_nxt;
  logic [WORD_W-1:0]   iw_q_r, iw_q_nxt, cw_q_r, cw_q_nxt;
  logic [FREQ_W-1:0]   m_r, m_nxt;
  logic [SIG_W-1:0]    ms_r, ms_nxt;
  logic                f_ge_r, f_ge_nxt, s_ge_r, s_ge_nxt;

  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [1:0]       mul_idx_r, mul_idx_nxt;

  logic [USED_W-1:0] iss_r, iss_nxt;
  logic              cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]  cmp_idx_r, cmp_idx_nxt;

  logic [DIVR_W-1:0] div_rem_r, div_rem_nxt;
  logic [ACC_W-1:0]  div_quo_r, div_quo_nxt;
  logic [DIVC_W-1:0] div_cnt_r, div_cnt_nxt;
  logic              div_busy_r, div_busy_nxt;

  logic [SPREAD_W-1:0] t1_r, t1_nxt, t2_r, t2_nxt;
  logic [FREQ_W-1:0]   qm_r, qm_nxt;
  logic [SIG_W-1:0]    qs_r, qs_nxt;
  logic [WSEL_W-1:0]   sweep_r, sweep_nxt;

  logic [1:0]          res_status_r, res_status_nxt;
  logic [IDX_W-1:0]    res_idx_r, res_idx_nxt;
  logic [FREQ_W-1:0]   res_mean_r, res_mean_nxt;
  logic [SPREAD_W-1:0] res_spread_r, res_spread_nxt;
  logic [SIG_W-1:0]    res_sig_r, res_sig_nxt;
  logic [CNT_W-1:0]    res_cnt_r, res_cnt_nxt;
  logic [WORD_W-1:0]   res_tw_r, res_tw_nxt, res_cw_r, res_cw_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [1:0]          out_status_r;
  logic [IDX_W-1:0]    out_idx_r;
  logic [FREQ_W-1:0]   out_mean_r;
  logic [SPREAD_W-1:0] out_spread_r;
  logic [SIG_W-1:0]    out_sig_r;
  logic [CNT_W-1:0]    out_cnt_r;
  logic [WORD_W-1:0]   out_tw_r, out_cw_r;
  logic [USED_W-1:0]   out_used_r;
  logic                out_load;

  // memory ports
  logic                stat_we;
  logic [IDX_W-1:0]    stat_addr;
  logic [FREQ_W-1:0]   mean_wdata, mean_rdata;
  logic [SPREAD_W-1:0] spread_wdata, spread_rdata;
  logic [SIG_W-1:0]    sig_wdata, sig_rdata;
  logic [CNT_W-1:0]    cnt_wdata, cnt_rdata;
  logic                bm_we;
  logic [BMAP_AW-1:0]  bm_iaddr, bm_caddr;
  logic [WORD_W-1:0]   bm_iwdata, bm_cwdata, bm_irdata, bm_crdata;

  // shared multiplier
  logic [MUL_W-1:0]   mul_a, mul_b;
  logic [1:0]         mul_sh;
  logic [2*MUL_W-1:0] prod;
  logic [ACC_W-1:0]   prod_sh, acc_add;

  // shared divider
  logic [ACC_W-1:0]    div_dividend;
  logic [DIVR_W-1:0]   div_divisor;
  logic [DIVR_W:0]     div_rem_sh;
  logic                div_ge;
  logic [DIVR_W-1:0]   div_step_rem;
  logic [ACC_W-1:0]    div_step_quo;
  logic                div_done;
  logic [SPREAD_W-1:0] div_quo_sat;

  // misc datapath
  logic [FREQ_W-1:0]   scan_d;
  logic                scan_hit;
  logic [CNT_W:0]      d1;
  logic [FREQ_W+1:0]   mm2;
  logic [SIG_W+1:0]    ss2;
  logic [SPREAD_W:0]   spread_sum;
  logic [WORD_W-1:0]   ibit, cbit;
  logic                cfg_wr;

  btmu_ram #(.WIDTH(FREQ_W), .DEPTH(TABLE_DEPTH)) u_mean_ram (
    .clk, .we(stat_we), .addr(stat_addr), .wdata(mean_wdata), .rdata(mean_rdata));
  btmu_ram #(.WIDTH(SPREAD_W), .DEPTH(TABLE_DEPTH)) u_spread_ram (
    .clk, .we(stat_we), .addr(stat_addr), .wdata(spread_wdata), .rdata(spread_rdata));
  btmu_ram #(.WIDTH(SIG_W), .DEPTH(TABLE_DEPTH)) u_sig_ram (
    .clk, .we(stat_we), .addr(stat_addr), .wdata(sig_wdata), .rdata(sig_rdata));
  btmu_ram #(.WIDTH(CNT_W), .DEPTH(TABLE_DEPTH)) u_cnt_ram (
    .clk, .we(stat_we), .addr(stat_addr), .wdata(cnt_wdata), .rdata(cnt_rdata));
  btmu_ram #(.WIDTH(WORD_W), .DEPTH(BMAP_DEPTH)) u_imap_ram (
    .clk, .we(bm_we), .addr(bm_iaddr), .wdata(bm_iwdata), .rdata(bm_irdata));
  btmu_ram #(.WIDTH(WORD_W), .DEPTH(BMAP_DEPTH)) u_cmap_ram (
    .clk, .we(bm_we), .addr(bm_caddr), .wdata(bm_cwdata), .rdata(bm_crdata));

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_TOL_IDX) ? {{(32-TOL_W){1'b0}}, tol_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else if (cfg_wr && paddr[2] == REG_TOL_IDX) begin
      tol_r <= pwdata[TOL_W-1:0];
    end
  end

  // fixed datapath pieces
  assign prod = mul_a * mul_b;
  always_comb begin
    unique case (mul_sh)
      2'd0:    prod_sh = {{(ACC_W-2*MUL_W){1'b0}}, prod};
      2'd1:    prod_sh = {{(ACC_W-2*MUL_W-MUL_W){1'b0}}, prod, {MUL_W{1'b0}}};
      default: prod_sh = {prod, {(2*MUL_W){1'b0}}};
    endcase
  end
  assign acc_add = ((mul_idx_r == 2'd0) ? {ACC_W{1'b0}} : acc_r) + prod_sh;

  assign div_rem_sh   = {div_rem_r, div_quo_r[ACC_W-1]};
  assign div_ge       = div_rem_sh >= {1'b0, div_divisor};
  assign div_step_rem = div_ge ? DIVR_W'(div_rem_sh - {1'b0, div_divisor})
                               : div_rem_sh[DIVR_W-1:0];
  assign div_step_quo = {div_quo_r[ACC_W-2:0], div_ge};
  assign div_quo_sat  = (|div_step_quo[ACC_W-1:SPREAD_W]) ? {SPREAD_W{1'b1}}
                                                          : div_step_quo[SPREAD_W-1:0];

  assign scan_d   = (mean_rdata >= f_r) ? mean_rdata - f_r : f_r - mean_rdata;
  assign scan_hit = cmp_vld_r && ({scan_d, {TOL_W{1'b0}}} < acc_r[FREQ_W+TOL_W-1:0]);

  assign d1  = {1'b0, cnt_q_r} + {{CNT_W{1'b0}}, 1'b1};
  assign mm2 = {1'b0, m_r, 1'b0} + {{(FREQ_W+1-CNT_W){1'b0}}, d1};
  assign ss2 = {1'b0, ms_r, 1'b0} + {{(SIG_W+1-CNT_W){1'b0}}, d1};
  assign spread_sum = {1'b0, t1_r} + {1'b0, t2_r};
  assign ibit = {{(WORD_W-1){1'b0}}, 1'b1} << iv_r[5:0];
  assign cbit = {{(WORD_W-1){1'b0}}, 1'b1} << ch_r[5:0];

  always_comb begin
    state_nxt    = state_r;
    used_nxt     = used_r;
    e_nxt        = e_r;
    f_nxt        = f_r;
    s_nxt        = s_r;
    iv_nxt       = iv_r;
    ch_nxt       = ch_r;
    ws_nxt       = ws_r;
    append_nxt   = append_r;
    mean_q_nxt   = mean_q_r;
    spread_q_nxt = spread_q_r;
    sig_q_nxt    = sig_q_r;
    cnt_q_nxt    = cnt_q_r;
    iw_q_nxt     = iw_q_r;
    cw_q_nxt     = cw_q_r;
    m_nxt        = m_r;
    ms_nxt       = ms_r;
    f_ge_nxt     = f_ge_r;
    s_ge_nxt     = s_ge_r;
    acc_nxt      = acc_r;
    mul_idx_nxt  = mul_idx_r;
    iss_nxt      = iss_r;
    cmp_vld_nxt  = 1'b0;
    cmp_idx_nxt  = cmp_idx_r;
    div_rem_nxt  = div_rem_r;
    div_quo_nxt  = div_quo_r;
    div_cnt_nxt  = div_cnt_r;
    div_busy_nxt = div_busy_r;
    div_done     = 1'b0;
    t1_nxt       = t1_r;
    t2_nxt       = t2_r;
    qm_nxt       = qm_r;
    qs_nxt       = qs_r;
    sweep_nxt    = sweep_r;
    res_status_nxt = res_status_r;
    res_idx_nxt    = res_idx_r;
    res_mean_nxt   = res_mean_r;
    res_spread_nxt = res_spread_r;
    res_sig_nxt    = res_sig_r;
    res_cnt_nxt    = res_cnt_r;
    res_tw_nxt     = res_tw_r;
    res_cw_nxt     = res_cw_r;
    out_load       = 1'b0;

    stat_we      = 1'b0;
    stat_addr    = e_r;
    mean_wdata   = f_r;
    spread_wdata = '0;
    sig_wdata    = s_r;
    cnt_wdata    = {{(CNT_W-1){1'b0}}, 1'b1};
    bm_we        = 1'b0;
    bm_iaddr     = {e_r, iv_r[6 +: WSEL_W]};
    bm_caddr     = {e_r, ch_r[6 +: WSEL_W]};
    bm_iwdata    = iw_q_r | ibit;
    bm_cwdata    = cw_q_r | cbit;

    mul_a        = '0;
    mul_b        = '0;
    mul_sh       = 2'd0;
    div_dividend = acc_r;
    div_divisor  = {1'b0, d1};

    // divider operands by phase
    unique case (state_r)
      S_UPD_DIV_T1: div_divisor = {{(DIVR_W-CNT_W){1'b0}}, cnt_q_r};
      S_UPD_DIV_M: begin
        div_dividend = {{(ACC_W-FREQ_W-2){1'b0}}, mm2};
        div_divisor  = {d1, 1'b0};
      end
      S_UPD_DIV_S: begin
        div_dividend = {{(ACC_W-SIG_W-2){1'b0}}, ss2};
        div_divisor  = {d1, 1'b0};
      end
      default: ;
    endcase

    // one step of the shared divider; first cycle of each phase loads it
    if (state_r == S_UPD_DIV_T2 || state_r == S_UPD_DIV_T1 ||
        state_r == S_UPD_DIV_M || state_r == S_UPD_DIV_S) begin
      if (!div_busy_r) begin
        div_busy_nxt = 1'b1;
        div_cnt_nxt  = '0;
        div_rem_nxt  = '0;
        div_quo_nxt  = div_dividend;
      end else begin
        div_rem_nxt = div_step_rem;
        div_quo_nxt = div_step_quo;
        div_cnt_nxt = div_cnt_r + 1'b1;
        if (div_cnt_r == DIV_LAST) begin
          div_busy_nxt = 1'b0;
          div_done     = 1'b1;
        end
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          e_nxt  = in_entry_index;
          f_nxt  = in_tone_freq;
          s_nxt  = in_tone_sigma;
          iv_nxt = in_interval_number;
          ch_nxt = in_chan_number;
          ws_nxt = in_word_select;
          res_status_nxt = STAT_BADIDX;
          res_idx_nxt    = '0;
          res_mean_nxt   = '0;
          res_spread_nxt = '0;
          res_sig_nxt    = '0;
          res_cnt_nxt    = '0;
          res_tw_nxt     = '0;
          res_cw_nxt     = '0;
          state_nxt      = S_DONE;
          unique case (in_command)
            CMD_FIND: begin
              mul_idx_nxt = 2'd0;
              state_nxt   = S_FIND_MUL;
            end
            CMD_UPDATE: begin
              if ({1'b0, in_entry_index} <= used_r) begin
                append_nxt = ({1'b0, in_entry_index} == used_r);
                state_nxt  = S_UPD_RD;
              end
            end
            CMD_READ: begin
              if ({1'b0, in_entry_index} < used_r) begin
                res_status_nxt = STAT_OK;
                state_nxt      = S_RD_ISSUE;
              end
            end
            default: ;
          endcase
        end
      end

      // bound = tolerance * f, two partial products
      S_FIND_MUL: begin
        mul_a       = tol_r;
        mul_b       = (mul_idx_r == 2'd0) ? f_r[MUL_W-1:0] : f_r[FREQ_W-1:MUL_W];
        mul_sh      = mul_idx_r;
        acc_nxt     = acc_add;
        mul_idx_nxt = mul_idx_r + 1'b1;
        if (mul_idx_r == 2'd1) begin
          mul_idx_nxt = 2'd0;
          iss_nxt     = '0;
          state_nxt   = S_FIND_SCAN;
        end
      end

      // issue one mean read a cycle, compare the one returned
      S_FIND_SCAN: begin
        stat_addr = iss_r[IDX_W-1:0];
        if (scan_hit) begin
          e_nxt          = cmp_idx_r;
          res_status_nxt = STAT_OK;
          state_nxt      = S_RD_ISSUE;
        end else if (iss_r == used_r) begin
          res_status_nxt = STAT_NOMATCH;
          state_nxt      = S_DONE;
        end else begin
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = iss_r[IDX_W-1:0];
          iss_nxt     = iss_r + 1'b1;
        end
      end

      S_UPD_RD: state_nxt = S_UPD_LAT;

      S_UPD_LAT: begin
        mean_q_nxt   = mean_rdata;
        spread_q_nxt = spread_rdata;
        sig_q_nxt    = sig_rdata;
        cnt_q_nxt    = cnt_rdata;
        iw_q_nxt     = bm_irdata;
        cw_q_nxt     = bm_crdata;
        sweep_nxt    = '0;
        state_nxt    = append_r ? S_UPD_SWEEP : S_UPD_BITS;
      end

      // fresh entry: clear its bitmap rows, set the detection bits, initialize its stats
      S_UPD_SWEEP: begin
        bm_we     = 1'b1;
        bm_iaddr  = {e_r, sweep_r};
        bm_caddr  = {e_r, sweep_r};
        bm_iwdata = (sweep_r == iv_r[6 +: WSEL_W]) ? ibit : '0;
        bm_cwdata = (sweep_r == ch_r[6 +: WSEL_W]) ? cbit : '0;
        stat_we   = (sweep_r == '0);
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == WSEL_W'(BMAP_WORDS - 1)) begin
          used_nxt       = used_r + 1'b1;
          res_status_nxt = STAT_OK;
          state_nxt      = S_RD_ISSUE;
        end
      end

      S_UPD_BITS: begin
        bm_we       = 1'b1;
        f_ge_nxt    = f_r >= mean_q_r;
        s_ge_nxt    = s_r >= sig_q_r;
        m_nxt       = (f_r >= mean_q_r) ? f_r - mean_q_r : mean_q_r - f_r;
        ms_nxt      = (s_r >= sig_q_r) ? s_r - sig_q_r : sig_q_r - s_r;
        mul_idx_nxt = 2'd0;
        state_nxt   = S_UPD_MM;
      end

      // d*d from four 24x24 partial products
      S_UPD_MM: begin
        mul_a       = mul_idx_r[1] ? m_r[FREQ_W-1:MUL_W] : m_r[MUL_W-1:0];
        mul_b       = mul_idx_r[0] ? m_r[FREQ_W-1:MUL_W] : m_r[MUL_W-1:0];
        mul_sh      = {1'b0, mul_idx_r[1]} + {1'b0, mul_idx_r[0]};
        acc_nxt     = acc_add;
        mul_idx_nxt = mul_idx_r + 1'b1;
        if (mul_idx_r == 2'd3) begin
          mul_idx_nxt = 2'd0;
          state_nxt   = S_UPD_DIV_T2;
        end
      end

      S_UPD_DIV_T2: begin
        if (div_done) begin
          t2_nxt      = div_quo_sat;
          mul_idx_nxt = 2'd0;
          state_nxt   = S_UPD_SP;
        end
      end

      // spread * (n-1) from three partial products
      S_UPD_SP: begin
        unique case (mul_idx_r)
          2'd0:    mul_a = spread_q_r[MUL_W-1:0];
          2'd1:    mul_a = spread_q_r[2*MUL_W-1:MUL_W];
          default: mul_a = {{(3*MUL_W-SPREAD_W){1'b0}}, spread_q_r[SPREAD_W-1:2*MUL_W]};
        endcase
        mul_b       = cnt_q_r - 1'b1;
        mul_sh      = mul_idx_r;
        acc_nxt     = acc_add;
        mul_idx_nxt = mul_idx_r + 1'b1;
        if (mul_idx_r == 2'd2) begin
          mul_idx_nxt = 2'd0;
          state_nxt   = S_UPD_DIV_T1;
        end
      end

      S_UPD_DIV_T1: begin
        if (div_done) begin
          t1_nxt    = div_quo_sat;
          state_nxt = S_UPD_DIV_M;
        end
      end

      S_UPD_DIV_M: begin
        if (div_done) begin
          qm_nxt    = div_step_quo[FREQ_W-1:0];
          state_nxt = S_UPD_DIV_S;
        end
      end

      S_UPD_DIV_S: begin
        if (div_done) begin
          qs_nxt    = div_step_quo[SIG_W-1:0];
          state_nxt = S_UPD_WR;
        end
      end

      S_UPD_WR: begin
        stat_we      = 1'b1;
        mean_wdata   = f_ge_r ? mean_q_r + qm_r : mean_q_r - qm_r;
        sig_wdata    = s_ge_r ? sig_q_r + qs_r : sig_q_r - qs_r;
        spread_wdata = spread_sum[SPREAD_W] ? {SPREAD_W{1'b1}} : spread_sum[SPREAD_W-1:0];
        cnt_wdata    = (cnt_q_r == CNT_MAX) ? cnt_q_r : cnt_q_r + 1'b1;
        res_status_nxt = STAT_OK;
        state_nxt      = S_RD_ISSUE;
      end

      S_RD_ISSUE: begin
        bm_iaddr  = {e_r, ws_r};
        bm_caddr  = {e_r, ws_r};
        state_nxt = S_RD_DATA;
      end

      S_RD_DATA: begin
        res_idx_nxt    = e_r;
        res_mean_nxt   = mean_rdata;
        res_spread_nxt = spread_rdata;
        res_sig_nxt    = sig_rdata;
        res_cnt_nxt    = cnt_rdata;
        res_tw_nxt     = bm_irdata;
        res_cw_nxt     = bm_crdata;
        state_nxt      = S_DONE;
      end

      // hold until the output register is free
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
    endcase

    out_valid_nxt = (out_valid_r && out_stall) || out_load;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
      div_busy_r  <= 1'b0;
      cmp_vld_r   <= 1'b0;
      mul_idx_r   <= 2'd0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
      div_busy_r  <= div_busy_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      mul_idx_r   <= mul_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e_r        <= e_nxt;
    f_r        <= f_nxt;
    s_r        <= s_nxt;
    iv_r       <= iv_nxt;
    ch_r       <= ch_nxt;
    ws_r       <= ws_nxt;
    append_r   <= append_nxt;
    mean_q_r   <= mean_q_nxt;
    spread_q_r <= spread_q_nxt;
    sig_q_r    <= sig_q_nxt;
    cnt_q_r    <= cnt_q_nxt;
    iw_q_r     <= iw_q_nxt;
    cw_q_r     <= cw_q_nxt;
    m_r        <= m_nxt;
    ms_r       <= ms_nxt;
    f_ge_r     <= f_ge_nxt;
    s_ge_r     <= s_ge_nxt;
    acc_r      <= acc_nxt;
    iss_r      <= iss_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    div_rem_r  <= div_rem_nxt;
    div_quo_r  <= div_quo_nxt;
    div_cnt_r  <= div_cnt_nxt;
    t1_r       <= t1_nxt;
    t2_r       <= t2_nxt;
    qm_r       <= qm_nxt;
    qs_r       <= qs_nxt;
    sweep_r    <= sweep_nxt;
    res_status_r <= res_status_nxt;
    res_idx_r    <= res_idx_nxt;
    res_mean_r   <= res_mean_nxt;
    res_spread_r <= res_spread_nxt;
    res_sig_r    <= res_sig_nxt;
    res_cnt_r    <= res_cnt_nxt;
    res_tw_r     <= res_tw_nxt;
    res_cw_r     <= res_cw_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_idx_r    <= res_idx_r;
      out_mean_r   <= res_mean_r;
      out_spread_r <= res_spread_r;
      out_sig_r    <= res_sig_r;
      out_cnt_r    <= res_cnt_r;
      out_tw_r     <= res_tw_r;
      out_cw_r     <= res_cw_r;
      out_used_r   <= used_r;
    end
  end

  assign in_stall           = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_match_index    = out_idx_r;
  assign out_freq_mean      = out_mean_r;
  assign out_freq_spread    = out_spread_r;
  assign out_sigma_mean     = out_sig_r;
  assign out_obs_count      = out_cnt_r;
  assign out_time_word      = out_tw_r;
  assign out_chan_word      = out_cw_r;
  assign out_entries_in_use = out_used_r;

endmodule

// File: hw/rtl/btmu_ram.sv
`timescale 1ns / 1ps
// Generic single-port RAM with registered read.
module btmu_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: hw/rtl/btmu_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the birdie table unit and their bind.
module btmu_checker
  import btmu_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic [1:0]          out_status,
  input logic [IDX_W-1:0]    out_match_index,
  input logic [FREQ_W-1:0]   out_freq_mean,
  input logic [CNT_W-1:0]    out_obs_count,
  input logic [WORD_W-1:0]   out_time_word,
  input logic [USED_W-1:0]   out_entries_in_use
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status))
    else $error("result dropped or changed under stall");

  // an accepted request keeps the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted without going busy");

  a_nomatch_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STAT_NOMATCH || out_status == STAT_BADIDX) |->
      out_match_index == '0 && out_freq_mean == '0 && out_obs_count == '0 &&
      out_time_word == '0)
    else $error("entry fields not zero on failed request");

  a_ok_entry: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STAT_OK |->
      out_obs_count != '0 && out_entries_in_use != '0 &&
      out_entries_in_use <= USED_W'(TABLE_DEPTH))
    else $error("ok result from an empty entry");

endmodule

bind birdie_table_match_update_unit btmu_checker u_btmu_checker (.*);
